// ===== hw/rtl/ssm_pkg.sv =====
// Shared types and constants for the streaming substring matcher.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

  // Needle and code unit geometry
  localparam int NEEDLE_MAX     = 16;
  localparam int UNIT_BITS      = 16;
  localparam int SLOT_BITS      = 16;
  localparam int SLOTS_PER_WORD = 4;
  localparam int NEEDLE_WORDS   = 4;
  localparam int LEN_FIELD_W    = 5;
  localparam int LEN_W          = $clog2(NEEDLE_MAX + 1);
  localparam int IDX_W          = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

  // Scan counters and reported values
  localparam int INDEX_W = 32;
  localparam int POS_W   = 31;

  // Configuration port
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int REG_W    = 3;
  localparam int REG_LSB  = 3;

  localparam logic [REG_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [REG_W-1:0] REG_NEEDLE_A      = 3'd1;
  localparam logic [REG_W-1:0] REG_NEEDLE_B      = 3'd2;
  localparam logic [REG_W-1:0] REG_NEEDLE_C      = 3'd3;
  localparam logic [REG_W-1:0] REG_NEEDLE_D      = 3'd4;
  localparam logic [REG_W-1:0] REG_MATCH_ALL     = 3'd5;
  localparam logic [REG_W-1:0] REG_START_OFFSET  = 3'd6;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Result parts of one job, in delivery order
  localparam int PART_M = 0;
  localparam int PART_E = 1;
  localparam int PART_F = 2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } unit_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] match_count;
    logic             run_end;
  } result_t;

  typedef struct packed {
    logic [LEN_FIELD_W-1:0]                 needle_length;
    logic [NEEDLE_WORDS-1:0][DATA_W-1:0]    needle_words;
    logic                                   match_all;
    logic [POS_W-1:0]                       start_offset;
  } cfg_t;

  // Everything one accepted unit asks the back end to report
  typedef struct packed {
    logic             m_valid;
    logic [POS_W-1:0] m_pos;
    logic [POS_W-1:0] m_cnt;
    logic             e_valid;
    logic             fin;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] end_cnt;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssm_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on ssm_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module ssm_regs
  import ssm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg
);

  logic [REG_W-1:0] index;
  logic             wr_en;

  assign index  = paddr[REG_LSB +: REG_W];
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (index)
        REG_NEEDLE_LENGTH: cfg.needle_length <= pwdata[LEN_FIELD_W-1:0];
        REG_NEEDLE_A:      cfg.needle_words[0] <= pwdata;
        REG_NEEDLE_B:      cfg.needle_words[1] <= pwdata;
        REG_NEEDLE_C:      cfg.needle_words[2] <= pwdata;
        REG_NEEDLE_D:      cfg.needle_words[3] <= pwdata;
        REG_MATCH_ALL:     cfg.match_all <= pwdata[0];
        REG_START_OFFSET:  cfg.start_offset <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_NEEDLE_LENGTH: prdata = DATA_W'(cfg.needle_length);
      REG_NEEDLE_A:      prdata = cfg.needle_words[0];
      REG_NEEDLE_B:      prdata = cfg.needle_words[1];
      REG_NEEDLE_C:      prdata = cfg.needle_words[2];
      REG_NEEDLE_D:      prdata = cfg.needle_words[3];
      REG_MATCH_ALL:     prdata = DATA_W'(cfg.match_all);
      REG_START_OFFSET:  prdata = DATA_W'(cfg.start_offset);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_front.sv =====
// Front end: takes one code unit per cycle while the queue is not full, shifts the
// window, compares it against the needle and decides which reports the unit causes. Uses ssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssm_front
  import ssm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  unit_valid,
  input  wire unit_t unit_data,
  input  wire logic  full,
  output      logic  unit_stall,
  output      logic  push,
  output      job_t  job
);

  logic [NEEDLE_MAX-1:0][UNIT_BITS-1:0] window;
  logic [NEEDLE_MAX-1:0][UNIT_BITS-1:0] window_next;
  logic [NEEDLE_MAX-1:0][UNIT_BITS-1:0] needle;
  logic [LEN_W-1:0]                     fill;
  logic [LEN_W-1:0]                     fill_next;
  logic [INDEX_W-1:0]                   unit_index;
  logic [INDEX_W-1:0]                   next_start;
  logic [INDEX_W-1:0]                   seen;
  logic                                 found_any;

  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      midx;
  logic [NEEDLE_MAX-1:0] eq;
  logic [NEEDLE_MAX-1:0] mask;
  logic                  len_zero;
  logic                  match_eq;
  logic                  may_base;
  logic                  hit;
  logic                  e_hit;
  logic                  fin;
  logic                  accept;
  logic [INDEX_W-1:0]    start_pos;
  logic [INDEX_W-1:0]    total;
  logic [INDEX_W-1:0]    seen_after;

  assign unit_stall = full;
  assign accept     = unit_valid & ~unit_stall;
  assign fin        = unit_data.final_unit;

  always_comb begin
    for (int m = 0; m < NEEDLE_MAX; m++) begin
      needle[m] = cfg.needle_words[m / SLOTS_PER_WORD]
                    [(m % SLOTS_PER_WORD) * SLOT_BITS +: UNIT_BITS];
    end
  end

  always_comb begin
    window_next[0] = unit_data.code_unit[UNIT_BITS-1:0];
    for (int p = 1; p < NEEDLE_MAX; p++) begin
      window_next[p] = window[p-1];
    end
    fill_next = (fill < LEN_W'(NEEDLE_MAX)) ? fill + LEN_W'(1) : fill;
  end

  always_comb begin
    len = (cfg.needle_length > LEN_FIELD_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                         : cfg.needle_length[LEN_W-1:0];
    midx = '0;
    // Window slot p holds needle unit len-1-p
    for (int p = 0; p < NEEDLE_MAX; p++) begin
      mask[p] = LEN_W'(p) < len;
      midx    = len - LEN_W'(p) - LEN_W'(1);
      eq[p]   = window_next[p] == needle[midx[IDX_W-1:0]];
    end
    match_eq = &(eq | ~mask);
    len_zero = len == '0;

    start_pos = len_zero ? unit_index
                         : unit_index - INDEX_W'(len) + INDEX_W'(1);
    total     = unit_index + INDEX_W'(1);
    may_base  = cfg.match_all | ~found_any;

    hit = (len_zero | ((fill_next >= len) & match_eq))
          & (start_pos >= INDEX_W'(cfg.start_offset))
          & may_base & (start_pos >= next_start);

    // Empty needle also matches at the end of the haystack
    e_hit = fin & len_zero & (hit ? cfg.match_all
                                  : (may_base & (total >= next_start)));

    seen_after = seen + INDEX_W'(hit) + INDEX_W'(e_hit);
  end

  always_comb begin
    push        = accept & (hit | e_hit | fin);
    job.m_valid = hit;
    job.m_pos   = start_pos[POS_W-1:0];
    job.m_cnt   = POS_W'(seen + INDEX_W'(1));
    job.e_valid = e_hit;
    job.fin     = fin;
    job.end_pos = total[POS_W-1:0];
    job.end_cnt = seen_after[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      unit_index <= '0;
      next_start <= '0;
      seen       <= '0;
      found_any  <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        fill       <= '0;
        unit_index <= '0;
        next_start <= '0;
        seen       <= '0;
        found_any  <= 1'b0;
      end else begin
        fill       <= fill_next;
        unit_index <= total;
        if (hit) begin
          // Resume the scan right after this match
          next_start <= total;
          seen       <= seen_after;
          found_any  <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_queue.sv =====
// Short job queue that decouples the front end from the result side.
// Uses ssm_pkg for job_t and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module ssm_queue
  import ssm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output      logic full,
  output      logic empty,
  output      job_t head
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_back.sv =====
// Back end: expands each queued job into one to three results and drives
// the registered result channel. Uses ssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssm_back
  import ssm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    empty,
  input  wire job_t    head,
  output      logic    pop,
  output      logic    result_valid,
  input  wire logic    result_stall,
  output      result_t result_data
);

  logic [2:0] done;
  logic [2:0] parts;
  logic [2:0] left;
  logic [2:0] pick;
  logic [2:0] rest;
  logic       advance;
  logic       take;
  result_t    next_result;

  always_comb begin
    parts[PART_M] = head.m_valid;
    parts[PART_E] = head.e_valid;
    parts[PART_F] = head.fin;
    left    = parts & ~done;
    pick    = left & (~left + 3'd1);
    rest    = left & ~pick;
    advance = ~result_valid | ~result_stall;
    take    = advance & ~empty;
    pop     = take & (rest == '0);
  end

  always_comb begin
    next_result.run_end = rest == '0;
    if (pick[PART_M]) begin
      next_result.kind        = KIND_MATCH;
      next_result.position    = head.m_pos;
      next_result.match_count = head.m_cnt;
    end else if (pick[PART_E]) begin
      next_result.kind        = KIND_MATCH;
      next_result.position    = head.end_pos;
      next_result.match_count = head.end_cnt;
    end else begin
      next_result.kind        = KIND_END;
      next_result.position    = head.end_pos;
      next_result.match_count = head.end_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_data <= next_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      done         <= '0;
    end else begin
      if (take) begin
        result_valid <= 1'b1;
        // Clear progress once the job's last part goes out
        done <= pop ? '0 : (done | pick);
      end else if (advance) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/streaming_substring_matcher.sv =====
// Streaming substring matcher: one haystack code unit per cycle while the job
// queue has room, needle of up to 16 units compared in parallel against a
// shift window in the front end. An accepted unit's job enters the job queue,
// then the result register loads its first result, which transfers while
// result_stall is low. Throughput: the result register moves one result per
// cycle when not stalled; a final unit with an empty needle yields up to three.
// Reset: synchronous; clears the registers, scan state, queue and result valid.
`timescale 1ns / 1ps
`default_nettype none

module streaming_substring_matcher
  import ssm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              unit_valid,
  output      logic              unit_stall,
  input  wire unit_t             unit_data,
  output      logic              result_valid,
  input  wire logic              result_stall,
  output      result_t           result_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  cfg_t cfg;
  job_t job;
  job_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  ssm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .unit_valid (unit_valid),
    .unit_data  (unit_data),
    .full       (full),
    .unit_stall (unit_stall),
    .push       (push),
    .job        (job)
  );

  ssm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  ssm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

`ifndef SYNTHESIS
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (job.m_valid || job.e_valid || job.fin))
    else $error("queued job carries no result");

  a_end_match_final: assert property (@(posedge clk) disable iff (rst)
    (push && job.e_valid) |-> job.fin)
    else $error("end-of-string match on a unit that is not final");

  a_end_report_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.kind == KIND_END) |-> result_data.run_end)
    else $error("end report is not the last result of its unit");

  a_pop_when_avail: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== dv/match_report_checker.sv =====
// Report checker for the streaming substring matcher: follows register writes and
// unit transfers, predicts every match and end report, and compares them in order.
// Depends on ssm_pkg for the payload structs, register indexes and result kinds.
`timescale 1ns / 1ps

module match_report_checker
  import ssm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  input  logic              unit_stall,
  input  unit_t             unit_data,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                reports_due
);

  // Register copies
  logic [LEN_FIELD_W-1:0] needle_len;
  logic [DATA_W-1:0]      needle_word [NEEDLE_WORDS];
  logic                   every_match;
  logic [POS_W-1:0]       first_start;

  // Scan state of the current haystack
  logic [15:0] recent [NEEDLE_MAX];
  int          recent_fill;
  logic [31:0] unit_pos;
  logic [31:0] resume_pos;
  logic [31:0] hit_total;
  logic        hit_yet;

  result_t awaited_reports[$];
  result_t fresh_reports[$];
  int      mismatch_total = 0;

  function automatic logic eligible(logic [31:0] k);
    return (every_match || !hit_yet) && k >= resume_pos;
  endfunction

  function automatic void log_hit(logic [31:0] k, logic [31:0] stride);
    result_t r;
    hit_total  = hit_total + 1;
    hit_yet    = 1'b1;
    resume_pos = k + stride;
    r.kind        = KIND_MATCH;
    r.position    = k[POS_W-1:0];
    r.match_count = hit_total[POS_W-1:0];
    r.run_end     = 1'b0;
    fresh_reports.push_back(r);
  endfunction

  function automatic void restart_haystack();
    for (int j = 0; j < NEEDLE_MAX; j++) recent[j] = '0;
    recent_fill = 0;
    unit_pos    = '0;
    resume_pos  = '0;
    hit_total   = '0;
    hit_yet     = 1'b0;
  endfunction

  function automatic void absorb_unit(unit_t u);
    logic [31:0] i;
    logic [31:0] k;
    logic [31:0] total;
    int          len;
    logic        hit;
    logic [15:0] want;
    result_t     r;
    i = unit_pos;
    len = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
    fresh_reports.delete();
    for (int j = NEEDLE_MAX - 1; j > 0; j--) recent[j] = recent[j-1];
    recent[0] = u.code_unit;
    if (recent_fill < NEEDLE_MAX) recent_fill++;

    if (len == 0) begin
      // empty needle can hit before every unit at or past the start offset
      if (i >= first_start && eligible(i)) log_hit(i, 32'd1);
    end else if (recent_fill >= len) begin
      k = i - 32'(len - 1);
      hit = 1'b1;
      for (int m = 0; m < len; m++) begin
        want = needle_word[m / 4][(m % 4) * 16 +: 16];
        if (recent[len - 1 - m] != want) hit = 1'b0;
      end
      if (hit && k >= first_start && eligible(k)) log_hit(k, 32'(len));
    end
    unit_pos = i + 1;

    if (u.final_unit) begin
      total = i + 1;
      // empty needle also hits at the end, whatever the start offset
      if (len == 0 && eligible(total)) log_hit(total, 32'd1);
      r.kind        = KIND_END;
      r.position    = total[POS_W-1:0];
      r.match_count = hit_total[POS_W-1:0];
      r.run_end     = 1'b0;
      fresh_reports.push_back(r);
      restart_haystack();
    end

    if (fresh_reports.size() > 0) begin
      r = fresh_reports.pop_back();
      r.run_end = 1'b1;
      fresh_reports.push_back(r);
    end
    foreach (fresh_reports[q]) awaited_reports.push_back(fresh_reports[q]);
  endfunction

  always @(posedge clk) begin
    result_t want_r;
    if (rst) begin
      needle_len  = '0;
      for (int w = 0; w < NEEDLE_WORDS; w++) needle_word[w] = '0;
      every_match = 1'b0;
      first_start = '0;
      restart_haystack();
      awaited_reports.delete();
    end else begin
      // a unit sees the registers as they were before this edge
      if (unit_valid && !unit_stall) absorb_unit(unit_data);

      if (result_valid && !result_stall) begin
        if (awaited_reports.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: unexpected report kind=%0d position=%0d count=%0d last=%0d",
                     $time, result_data.kind, result_data.position,
                     result_data.match_count, result_data.run_end);
        end else begin
          want_r = awaited_reports.pop_front();
          if (want_r.kind !== result_data.kind || want_r.position !== result_data.position ||
              want_r.match_count !== result_data.match_count ||
              want_r.run_end !== result_data.run_end) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%0t: report mismatch expected kind=%0d position=%0d count=%0d last=%0d, got kind=%0d position=%0d count=%0d last=%0d",
                       $time, want_r.kind, want_r.position, want_r.match_count,
                       want_r.run_end, result_data.kind, result_data.position,
                       result_data.match_count, result_data.run_end);
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_LSB +: REG_W])
          REG_NEEDLE_LENGTH: needle_len     = pwdata[LEN_FIELD_W-1:0];
          REG_NEEDLE_A:      needle_word[0] = pwdata;
          REG_NEEDLE_B:      needle_word[1] = pwdata;
          REG_NEEDLE_C:      needle_word[2] = pwdata;
          REG_NEEDLE_D:      needle_word[3] = pwdata;
          REG_MATCH_ALL:     every_match    = pwdata[0];
          REG_START_OFFSET:  first_start    = pwdata[POS_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= mismatch_total;
    reports_due <= awaited_reports.size();
  end

endmodule

// ===== dv/streaming_substring_matcher_test.sv =====
// Top of the streaming substring matcher testbench: clock, reset, register writes,
// haystack stimulus with random gaps and stalls, and the final verdict.
// Depends on ssm_pkg, the matcher RTL and match_report_checker.
`timescale 1ns / 1ps

module streaming_substring_matcher_test;
  import ssm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIRECT_UNITS  = 17;
  localparam int RANDOM_UNITS  = 320;
  localparam int SQUEEZE_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              unit_valid;
  logic              unit_stall;
  unit_t             unit_data;
  logic              result_valid;
  logic              result_stall;
  result_t           result_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int reports_due;
  int cycle_count = 0;
  bit squeeze = 0;
  bit squeeze_served = 0;

  // Register values the stimulus is working with
  logic [LEN_FIELD_W-1:0] cfg_len;
  logic [DATA_W-1:0]      cfg_word [NEEDLE_WORDS];
  logic                   cfg_all;
  logic [POS_W-1:0]       cfg_off;

  logic [15:0] letters [3];
  logic [15:0] plant_q[$];
  int          hay_left = 0;
  int          units_fed = 0;

  streaming_substring_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .unit_data    (unit_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  match_report_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .unit_data    (unit_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .reports_due  (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall runs, plus one long hold-off on request
  initial begin
    int  run;
    int  hold_left;
    int  roll;
    bit  hold;
    run = 0;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeeze_served) begin
        squeeze_served = 1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        run = 0;
        result_stall <= 1'b1;
      end else if (run == 0) begin
        roll = $urandom_range(0, 99);
        hold = (roll < 35);
        if (!hold) run = $urandom_range(1, 20);
        else if ($urandom_range(0, 99) < 85) run = $urandom_range(1, 3);
        else run = $urandom_range(10, 40);
        result_stall <= hold;
        run--;
      end else begin
        run--;
      end
    end
  end

  task automatic send_unit(logic [15:0] code, logic fin);
    int    gap;
    int    roll;
    unit_t u;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 50);
    if (gap > 0) begin
      unit_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    u.code_unit  = code;
    u.final_unit = fin;
    unit_valid <= 1'b1;
    unit_data  <= u;
    do @(posedge clk); while (unit_stall);
    units_fed++;
  endtask

  task automatic apb_write(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config();
    apb_write(REG_NEEDLE_LENGTH, DATA_W'(cfg_len));
    apb_write(REG_NEEDLE_A, cfg_word[0]);
    apb_write(REG_NEEDLE_B, cfg_word[1]);
    apb_write(REG_NEEDLE_C, cfg_word[2]);
    apb_write(REG_NEEDLE_D, cfg_word[3]);
    apb_write(REG_MATCH_ALL, DATA_W'(cfg_all));
    apb_write(REG_START_OFFSET, DATA_W'(cfg_off));
  endtask

  // Drop valid, drain every awaited report, then let the pipeline empty
  task automatic settle();
    unit_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // Haystacks carry on across calls, so a phase may end mid-haystack
  task automatic feed_units(int count);
    int          active;
    int          roll;
    logic [15:0] code;
    active = (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(cfg_len);
    repeat (count) begin
      if (hay_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) hay_left = $urandom_range(1, 8);
        else if (roll < 90) hay_left = $urandom_range(9, 24);
        else hay_left = $urandom_range(25, 40);
        plant_q.delete();
      end
      if (plant_q.size() == 0 && active > 0 && $urandom_range(0, 99) < 25)
        for (int m = 0; m < active; m++)
          plant_q.push_back(cfg_word[m / 4][(m % 4) * 16 +: 16]);
      if (plant_q.size() > 0) code = plant_q.pop_front();
      else if ($urandom_range(0, 99) < 80) code = letters[$urandom_range(0, 2)];
      else code = 16'($urandom);
      hay_left--;
      send_unit(code, hay_left == 0);
    end
  endtask

  initial begin
    int phase;
    int roll;
    rst        <= 1'b1;
    unit_valid <= 1'b0;
    unit_data  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: empty needle, first match only
    send_unit(16'h0000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    settle();

    // Empty needle with the largest offset still hits at the end
    cfg_len = '0;
    for (int w = 0; w < NEEDLE_WORDS; w++) cfg_word[w] = '1;
    cfg_all = 1'b1;
    cfg_off = '1;
    load_config();
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0000, 1'b1);
    settle();

    // Repeated units: all mode skips overlapping hits
    cfg_len = 5'd2;
    cfg_off = '0;
    load_config();
    repeat (4) send_unit(16'hFFFF, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    settle();

    // First mode with a start offset
    cfg_all = 1'b0;
    cfg_off = 31'd1;
    load_config();
    repeat (3) send_unit(16'hFFFF, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    settle();

    // Oversized length clamps to a full needle, longer than the haystack
    cfg_len = '1;
    for (int w = 0; w < NEEDLE_WORDS; w++) cfg_word[w] = '0;
    cfg_all = 1'b1;
    cfg_off = '0;
    load_config();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0000, 1'b1);
    settle();

    // One-unit haystack equal to a one-unit needle
    cfg_len = 5'd1;
    load_config();
    send_unit(16'h0000, 1'b1);
    settle();

    phase = 0;
    while (units_fed < DIRECT_UNITS + RANDOM_UNITS) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) cfg_len = '0;
      else if (roll < 65) cfg_len = 5'($urandom_range(1, 4));
      else if (roll < 80) cfg_len = 5'($urandom_range(5, 15));
      else if (roll < 90) cfg_len = 5'd16;
      else cfg_len = 5'($urandom_range(17, 31));
      letters[0] = 16'($urandom);
      letters[1] = 16'($urandom);
      letters[2] = ~letters[0];
      for (int m = 0; m < NEEDLE_MAX; m++)
        cfg_word[m / 4][(m % 4) * 16 +: 16] = letters[$urandom_range(0, 2)];
      cfg_all = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 70) cfg_off = 31'($urandom_range(0, 3));
      else if (roll < 90) cfg_off = 31'($urandom_range(0, 20));
      else if (roll < 95) cfg_off = '1;
      else cfg_off = 31'($urandom);
      // every unit reports a match here, so the queue is sure to fill
      if (phase == 3) begin
        cfg_len = '0;
        cfg_all = 1'b1;
        cfg_off = '0;
      end
      load_config();
      // hold the result side off so the block backs up into its input
      if (phase == 3) squeeze <= 1'b1;
      feed_units($urandom_range(15, 45));
      settle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_regs.sv
hw/rtl/ssm_front.sv
hw/rtl/ssm_queue.sv
hw/rtl/ssm_back.sv
hw/rtl/streaming_substring_matcher.sv
dv/match_report_checker.sv
dv/streaming_substring_matcher_test.sv
